@@ design/mm_pkg.sv @@
// shared types and constants of the matrix multiply block
package mm_pkg;

  localparam int DIM_W  = 4;   // width of a dimension register
  localparam int IDX_W  = 3;   // width of a row or column tag
  localparam int VAL_W  = 32;  // Q16.16 element width
  localparam int FRAC_W = 16;  // fraction bits of an element
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 68;  // holds up to eight full Q32.32 terms with margin
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd3;

  typedef enum logic [1:0] {
    S_LOAD,
    S_ISSUE,
    S_WAIT,
    S_PUT
  } mm_state_t;

  // tags one term as it moves through the multiply-accumulate pipe
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

@@ design/mm_ram.sv @@
// single write port, single registered read port element store
module mm_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int W     = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/mm_mac.sv @@
// shared multiply-accumulate unit with rounding and saturation to Q16.16
module mm_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mm_pkg::mac_ctl_t              ctl_i,
  input  logic signed [mm_pkg::VAL_W-1:0] a_i,
  input  logic signed [mm_pkg::VAL_W-1:0] b_i,
  output logic                          done_o,
  output logic signed [mm_pkg::VAL_W-1:0] result_o
);
  import mm_pkg::*;

  mac_ctl_t                 ctl_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic                     done_r;
  logic signed [ACC_W-1:0]  rnd;
  logic                     ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= '0;
      done_r <= 1'b0;
    end else begin
      ctl_r  <= ctl_i;
      done_r <= ctl_r.valid && ctl_r.last;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a_i) * PROD_W'(b_i);
    if (ctl_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  // first term of an element restarts the sum
  assign acc_nxt = (ctl_r.first ? '0 : acc_r) + ACC_W'(prod_r);

  // round half up at the Q32.32 to Q16.16 step, then clip
  assign rnd = acc_r + $signed(ACC_W'(32'd32768));
  assign ovf = !((&rnd[ACC_W-1:FRAC_W+VAL_W-1]) || !(|rnd[ACC_W-1:FRAC_W+VAL_W-1]));

  always_comb begin
    if (ovf) begin
      result_o = rnd[ACC_W-1] ? $signed(32'h8000_0000) : $signed(32'h7FFF_FFFF);
    end else begin
      result_o = rnd[FRAC_W+VAL_W-1:FRAC_W];
    end
  end

  assign done_o = done_r;

endmodule

@@ design/matrix_multiply.sv @@
// matrix multiply top level: element stores, sequencer and output register
//
// Elements of A and B are written one per cycle while the block is loading; a
// transfer with in_last set starts the run with the dimensions held in the cfg
// registers (0 is taken as 1, above MAX_DIM as MAX_DIM). A dimension mismatch
// gives one error result. Otherwise each product element is computed on the
// single shared 32x32 multiply-accumulate unit (cols_a reads of the two stores,
// then multiply, accumulate and output register), and an output stall holds the
// run; in_ready is low during the run and comes back as soon as the last result
// sits in the output register. Unwritten store entries read as unknown.
module matrix_multiply #(
  parameter int MAX_DIM = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]         cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_target,
  input  logic [mm_pkg::IDX_W-1:0]         in_row,
  input  logic [mm_pkg::IDX_W-1:0]         in_col,
  input  logic signed [mm_pkg::VAL_W-1:0]  in_value,
  input  logic                             in_last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mm_pkg::IDX_W-1:0]         out_row,
  output logic [mm_pkg::IDX_W-1:0]         out_col,
  output logic signed [mm_pkg::VAL_W-1:0]  out_product,
  output logic                             out_final_res,
  output logic                             out_dim_error
);
  import mm_pkg::*;

  localparam int IW    = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

  logic [DIM_W-1:0] rows_a_r, cols_a_r, rows_b_r, cols_b_r;

  mm_state_t        state_r, state_nxt;
  logic [IW-1:0]    i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [DIM_W-1:0] ra_r, ra_nxt, ca_r, ca_nxt, cb_r, cb_nxt;
  logic             err_r, err_nxt;
  mac_ctl_t         rd_ctl_r, rd_ctl_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_row_r, out_col_r;
  logic signed [VAL_W-1:0] out_product_r;
  logic             out_final_r, out_err_r;
  logic             load;
  logic             i_end, j_end, k_end;

  logic             in_xfer, in_range;
  logic [AW-1:0]    waddr, a_raddr, b_raddr;
  logic signed [VAL_W-1:0] a_rdata, b_rdata, mac_result;
  logic             mac_done;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= DIM_W'(8);
      cols_a_r <= DIM_W'(8);
      rows_b_r <= DIM_W'(8);
      cols_b_r <= DIM_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS_A: rows_a_r <= cfg_data;
        CFG_COLS_A: cols_a_r <= cfg_data;
        CFG_ROWS_B: rows_b_r <= cfg_data;
        CFG_COLS_B: cols_b_r <= cfg_data;
        default:    rows_a_r <= rows_a_r;
      endcase
    end
  end

  // element stores
  assign in_xfer  = in_valid && in_ready;
  assign in_range = (DIM_W'(in_row) < DIM_W'(MAX_DIM)) && (DIM_W'(in_col) < DIM_W'(MAX_DIM));
  assign waddr    = AW'(in_row) * AW'(MAX_DIM) + AW'(in_col);
  assign a_raddr  = AW'(i_r) * AW'(MAX_DIM) + AW'(k_r);
  assign b_raddr  = AW'(k_r) * AW'(MAX_DIM) + AW'(j_r);

  mm_ram #(.DEPTH(DEPTH), .AW(AW), .W(VAL_W)) u_left (
    .clk   (clk),
    .we    (in_xfer && in_range && !in_target),
    .waddr (waddr),
    .wdata (in_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mm_ram #(.DEPTH(DEPTH), .AW(AW), .W(VAL_W)) u_right (
    .clk   (clk),
    .we    (in_xfer && in_range && in_target),
    .waddr (waddr),
    .wdata (in_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  mm_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (rd_ctl_r),
    .a_i      (a_rdata),
    .b_i      (b_rdata),
    .done_o   (mac_done),
    .result_o (mac_result)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      rd_ctl_r    <= '0;
      out_valid_r <= 1'b0;
      err_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_ctl_r    <= rd_ctl_nxt;
      out_valid_r <= out_valid_nxt;
      err_r       <= err_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ra_r <= ra_nxt;
    ca_r <= ca_nxt;
    cb_r <= cb_nxt;
    if (load) begin
      out_row_r     <= err_r ? '0 : IDX_W'(i_r);
      out_col_r     <= err_r ? '0 : IDX_W'(j_r);
      out_product_r <= err_r ? '0 : mac_result;
      out_final_r   <= err_r || (i_end && j_end);
      out_err_r     <= err_r;
    end
  end

  assign i_end = (i_r == IW'(ra_r - DIM_W'(1)));
  assign j_end = (j_r == IW'(cb_r - DIM_W'(1)));
  assign k_end = (k_r == IW'(ca_r - DIM_W'(1)));

  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    ra_nxt     = ra_r;
    ca_nxt     = ca_r;
    cb_nxt     = cb_r;
    err_nxt    = err_r;
    load       = 1'b0;
    in_ready   = 1'b0;
    rd_ctl_nxt = '0;
    case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid && in_last) begin
          ra_nxt = clamp_dim(rows_a_r);
          ca_nxt = clamp_dim(cols_a_r);
          cb_nxt = clamp_dim(cols_b_r);
          i_nxt  = '0;
          j_nxt  = '0;
          k_nxt  = '0;
          if (clamp_dim(cols_a_r) != clamp_dim(rows_b_r)) begin
            err_nxt   = 1'b1;
            state_nxt = S_PUT;
          end else begin
            err_nxt   = 1'b0;
            state_nxt = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        rd_ctl_nxt.valid = 1'b1;
        rd_ctl_nxt.first = (k_r == '0);
        rd_ctl_nxt.last  = k_end;
        if (k_end) begin
          k_nxt     = '0;
          state_nxt = S_WAIT;
        end else begin
          k_nxt = k_r + IW'(1);
        end
      end
      S_WAIT: begin
        if (mac_done) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        if (!out_valid_r || out_ready) begin
          load = 1'b1;
          if (err_r || (i_end && j_end)) begin
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_ISSUE;
            if (j_end) begin
              j_nxt = '0;
              i_nxt = i_r + IW'(1);
            end else begin
              j_nxt = j_r + IW'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_product   = out_product_r;
  assign out_final_res = out_final_r;
  assign out_dim_error = out_err_r;

`ifndef SYNTHESIS
  // the accumulator only finishes while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == S_WAIT)
    else $error("mac finished outside the wait state");

  // an error result is the only result of its run
  a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dim_error |-> out_final_res && out_product == '0)
    else $error("error result not marked final or not zero");

  // the term index never runs past the inner dimension
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ISSUE |-> DIM_W'(k_r) < ca_r)
    else $error("term index beyond inner dimension");

  // a run starts from the first element with a clean term counter
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> k_r == '0 && i_r == '0 && j_r == '0)
    else $error("run did not start at the first element");
`endif

endmodule

@@ tb/sv/tb.sv @@
// testbench for matrix_multiply: directed table, random load sequences, product checker
`timescale 1ns / 100ps

module tb;
  import mm_pkg::*;

  localparam int MAX_DIM       = 8;
  localparam int RANDOM_ITEMS  = 405;
  localparam int CYCLE_LIMIT   = 10000000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int HOLD_OFF      = 300;
  localparam int REPORT_FIRST  = 10;
  localparam int DIRECTED_ROWS = 23;
  localparam int CELL_W        = 1 + 2 * IDX_W;

  typedef struct packed {
    logic [DIM_W-1:0] ra;
    logic [DIM_W-1:0] ca;
    logic [DIM_W-1:0] rb;
    logic [DIM_W-1:0] cb;
  } dims_t;

  typedef struct packed {
    logic             target;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             last;
  } load_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] product;
    logic             final_res;
    logic             dim_error;
  } result_t;

  typedef struct packed {
    logic             target;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } cell_t;

  typedef struct packed {
    logic    reconfig;
    dims_t   dims;
    load_t   ld;
    logic    typed;
    result_t want;
  } dir_row_t;

  // dims are written before the row when reconfig is set; want is used when typed is set
  localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{1'b1, '{4'd1, 4'd1, 4'd1, 4'd1}, '{1'b0, 3'd0, 3'd0, 32'h0001_0000, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '{1'b1, 3'd0, 3'd0, 32'h0001_0000, 1'b1},
      1'b1, '{3'd0, 3'd0, 32'h0001_0000, 1'b1, 1'b0}},
    '{1'b0, '0, '{1'b0, 3'd0, 3'd0, 32'h8000_0000, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '{1'b1, 3'd0, 3'd0, 32'h8000_0000, 1'b1},
      1'b1, '{3'd0, 3'd0, 32'h7FFF_FFFF, 1'b1, 1'b0}},
    '{1'b0, '0, '{1'b0, 3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '{1'b1, 3'd0, 3'd0, 32'h8000_0000, 1'b1},
      1'b1, '{3'd0, 3'd0, 32'h8000_0000, 1'b1, 1'b0}},
    // half an lsb rounds up
    '{1'b0, '0, '{1'b0, 3'd0, 3'd0, 32'h0000_0001, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '{1'b1, 3'd0, 3'd0, 32'h0000_8000, 1'b1},
      1'b1, '{3'd0, 3'd0, 32'h0000_0001, 1'b1, 1'b0}},
    '{1'b0, '0, '{1'b0, 3'd0, 3'd0, 32'hFFFF_FFFF, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '{1'b1, 3'd0, 3'd0, 32'h0000_8000, 1'b1},
      1'b1, '{3'd0, 3'd0, 32'h0000_0000, 1'b1, 1'b0}},
    // zero dims act as one
    '{1'b1, '{4'd0, 4'd0, 4'd0, 4'd0}, '{1'b1, 3'd0, 3'd0, 32'h0003_0000, 1'b1}, 1'b0, '0},
    // inner dims disagree
    '{1'b1, '{4'd2, 4'd3, 4'd4, 4'd1}, '{1'b1, 3'd7, 3'd7, 32'hFFFF_FFFF, 1'b1},
      1'b1, '{3'd0, 3'd0, 32'h0000_0000, 1'b1, 1'b1}},
    // rows_a above the maximum acts as eight
    '{1'b1, '{4'd15, 4'd1, 4'd1, 4'd1}, '{1'b0, 3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '{1'b0, 3'd1, 3'd0, 32'h8000_0000, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '{1'b0, 3'd2, 3'd0, 32'h0001_0000, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '{1'b0, 3'd3, 3'd0, 32'hFFFF_0000, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '{1'b0, 3'd4, 3'd0, 32'h0000_0000, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '{1'b0, 3'd5, 3'd0, 32'h0002_8000, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '{1'b0, 3'd6, 3'd0, 32'hFFFF_FFFF, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '{1'b0, 3'd7, 3'd0, 32'h1234_5678, 1'b1}, 1'b0, '0},
    '{1'b1, '{4'd1, 4'd0, 4'd1, 4'd2}, '{1'b1, 3'd0, 3'd1, 32'h7FFF_FFFF, 1'b1}, 1'b0, '0},
    // twelve and seven clamp to eight and seven: still a mismatch
    '{1'b1, '{4'd1, 4'd12, 4'd7, 4'd1}, '{1'b0, 3'd5, 3'd2, 32'h0000_0000, 1'b1},
      1'b1, '{3'd0, 3'd0, 32'h0000_0000, 1'b1, 1'b1}},
    '{1'b1, '{4'd1, 4'd1, 4'd1, 4'd1}, '{1'b0, 3'd0, 3'd0, 32'h0000_0000, 1'b1},
      1'b1, '{3'd0, 3'd0, 32'h0000_0000, 1'b1, 1'b0}}
  };

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_ROWS_A;
  logic [DIM_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_target = 1'b0;
  logic [IDX_W-1:0]        in_row = '0;
  logic [IDX_W-1:0]        in_col = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    in_last = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [VAL_W-1:0] out_product;
  logic                    out_final_res;
  logic                    out_dim_error;

  // expectation that replaces the computed one for the item on the bus
  logic                    typed_on = 1'b0;
  result_t                 typed_res = '0;

  dims_t                   cfg_dims = '{4'd8, 4'd8, 4'd8, 4'd8};
  logic signed [VAL_W-1:0] left_mat  [MAX_DIM][MAX_DIM];
  logic signed [VAL_W-1:0] right_mat [MAX_DIM][MAX_DIM];
  logic [63:0]             a_loaded = '0;
  logic [63:0]             b_loaded = '0;
  result_t                 pending_products [$];

  int n_fail = 0;
  int n_loaded = 0;
  int n_products = 0;
  int n_dim_errors = 0;
  int n_saturated = 0;
  int n_configs = 0;
  int n_random_sent = 0;
  int n_offered = 0;
  int cycles = 0;
  bit send_steady = 1'b0;

  matrix_multiply #(.MAX_DIM(MAX_DIM)) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_target    (in_target),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_product  (out_product),
    .out_final_res(out_final_res),
    .out_dim_error(out_dim_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int usable_dim(input logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return int'(d);
  endfunction

  function automatic int idle_gap(input bit steady);
    int pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [VAL_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      1, 2, 3: return $urandom;
      // a few units either side of zero
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  // true when every element the next product reads has been loaded, or dims disagree
  function automatic bit operands_loaded();
    int ra, ca, cb;
    ra = usable_dim(cfg_dims.ra);
    ca = usable_dim(cfg_dims.ca);
    cb = usable_dim(cfg_dims.cb);
    if (ca != usable_dim(cfg_dims.rb)) return 1'b1;
    for (int i = 0; i < ra; i++)
      for (int k = 0; k < ca; k++)
        if (!a_loaded[i * MAX_DIM + k]) return 1'b0;
    for (int k = 0; k < ca; k++)
      for (int j = 0; j < cb; j++)
        if (!b_loaded[k * MAX_DIM + j]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void mark_loaded(input load_t ld);
    if (ld.target) b_loaded[ld.row * MAX_DIM + ld.col] = 1'b1;
    else a_loaded[ld.row * MAX_DIM + ld.col] = 1'b1;
  endfunction

  // append one expected result at the tail of the queue
  function automatic void expect_result(input result_t r);
    pending_products = {pending_products, r};
  endfunction

  // store one element; a last load queues the whole product, the mismatch flag, or the typed result
  task automatic load_and_multiply(input load_t ld, input bit typed, input result_t typed_val);
    int ra, ca, cb;
    result_t r;
    logic signed [2*VAL_W-1:0] term;
    logic signed [ACC_W-1:0]   total;
    if (ld.target) right_mat[ld.row][ld.col] = ld.value;
    else left_mat[ld.row][ld.col] = ld.value;
    if (ld.last) begin
      ra = usable_dim(cfg_dims.ra);
      ca = usable_dim(cfg_dims.ca);
      cb = usable_dim(cfg_dims.cb);
      if (typed) begin
        expect_result(typed_val);
      end else if (ca != usable_dim(cfg_dims.rb)) begin
        r = '0;
        r.final_res = 1'b1;
        r.dim_error = 1'b1;
        expect_result(r);
      end else begin
        for (int i = 0; i < ra; i++) begin
          for (int j = 0; j < cb; j++) begin
            total = '0;
            for (int k = 0; k < ca; k++) begin
              term = left_mat[i][k] * right_mat[k][j];
              total = total + term;
            end
            // round half toward plus infinity, then clip to Q16.16
            total = (total + 68'sd32768) >>> FRAC_W;
            r = '0;
            r.row = i[IDX_W-1:0];
            r.col = j[IDX_W-1:0];
            if (total > 68'sd2147483647) r.product = 32'h7FFF_FFFF;
            else if (total < -68'sd2147483648) r.product = 32'h8000_0000;
            else r.product = total[VAL_W-1:0];
            r.final_res = (i == ra - 1) && (j == cb - 1);
            expect_result(r);
          end
        end
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input result_t want, input result_t got);
    n_fail++;
    if (n_fail <= REPORT_FIRST)
      $display("%0t: %s: got row %0d col %0d product %h final %b err %b,",
               $realtime, what, got.row, got.col, got.product, got.final_res,
               got.dim_error,
               " expected row %0d col %0d product %h final %b err %b",
               want.row, want.col, want.product, want.final_res, want.dim_error);
  endtask

  always @(posedge clk) begin : watch
    load_t   seen;
    result_t got;
    result_t want;
    if (rst_n && in_valid && in_ready) begin
      seen.target = in_target;
      seen.row    = in_row;
      seen.col    = in_col;
      seen.value  = in_value;
      seen.last   = in_last;
      n_loaded++;
      load_and_multiply(seen, typed_on, typed_res);
    end
    if (rst_n && out_valid && out_ready) begin
      got.row       = out_row;
      got.col       = out_col;
      got.product   = out_product;
      got.final_res = out_final_res;
      got.dim_error = out_dim_error;
      if (got.dim_error === 1'b1) n_dim_errors++;
      else n_products++;
      if (got.dim_error !== 1'b1 &&
          (got.product === 32'h7FFF_FFFF || got.product === 32'h8000_0000))
        n_saturated++;
      if (pending_products.size() == 0) begin
        flag_mismatch("result with nothing expected", '0, got);
      end else begin
        want = pending_products.pop_front();
        if (got.row !== want.row || got.col !== want.col ||
            got.product !== want.product || got.final_res !== want.final_res ||
            got.dim_error !== want.dim_error)
          flag_mismatch("wrong result", want, got);
      end
    end
  end

  // result side: random stalls, one long hold-off while the sender keeps going
  initial begin : sink
    int stall;
    int turns;
    bit steady;
    bit held_off;
    turns = 0;
    steady = 1'b0;
    held_off = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (turns % 24 == 0) steady = ($urandom_range(0, 3) == 0);
      turns++;
      if (!held_off && n_products >= 60) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end
      stall = idle_gap(steady);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             pending_products.size());
    $display("** matrix_multiply: FAILED **");
    $finish;
  end

  // present one load and hold it until the transfer
  task automatic drive_load(input load_t ld, input bit typed, input result_t want);
    int gap;
    if (n_offered % 24 == 0) send_steady = ($urandom_range(0, 3) == 0);
    n_offered++;
    gap = idle_gap(send_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_target <= ld.target;
    in_row    <= ld.row;
    in_col    <= ld.col;
    in_value  <= ld.value;
    in_last   <= ld.last;
    typed_on  <= typed;
    typed_res <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_dims(input dims_t d);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROWS_A;
    cfg_data  <= d.ra;
    @(posedge clk);
    cfg_index <= CFG_COLS_A;
    cfg_data  <= d.ca;
    @(posedge clk);
    cfg_index <= CFG_ROWS_B;
    cfg_data  <= d.rb;
    @(posedge clk);
    cfg_index <= CFG_COLS_B;
    cfg_data  <= d.cb;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cfg_dims = d;
    n_configs++;
  endtask

  function automatic logic [DIM_W-1:0] encode_dim(input int d);
    if (d == 1 && $urandom_range(0, 3) == 0) return '0;
    if (d == MAX_DIM && $urandom_range(0, 1) == 0)
      return DIM_W'($urandom_range(MAX_DIM + 1, 15));
    return d[DIM_W-1:0];
  endfunction

  task automatic random_dims();
    int kind;
    int ra, ca, rb, cb;
    dims_t d;
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      ra = $urandom_range(1, MAX_DIM);
      cb = $urandom_range(1, MAX_DIM);
      ca = $urandom_range(1, MAX_DIM);
      rb = ca + $urandom_range(1, MAX_DIM - 1);
      if (rb > MAX_DIM) rb -= MAX_DIM;
    end else if (kind == 2) begin
      ra = $urandom_range(4, MAX_DIM);
      ca = $urandom_range(4, MAX_DIM);
      cb = $urandom_range(4, MAX_DIM);
      rb = ca;
    end else begin
      ra = $urandom_range(1, 3);
      ca = $urandom_range(1, 3);
      cb = $urandom_range(1, 3);
      rb = ca;
    end
    d.ra = encode_dim(ra);
    d.ca = encode_dim(ca);
    d.rb = encode_dim(rb);
    d.cb = encode_dim(cb);
    set_dims(d);
  endtask

  // random-content load; last only where no unloaded element could be read
  task automatic offer(input cell_t c, input bit force_last);
    load_t ld;
    ld.target = c.target;
    ld.row    = c.row;
    ld.col    = c.col;
    ld.value  = random_value();
    mark_loaded(ld);
    ld.last = force_last || (operands_loaded() && $urandom_range(0, 15) == 0);
    drive_load(ld, 1'b0, '0);
    n_random_sent++;
  endtask

  task automatic random_sequence();
    cell_t cells [2*MAX_DIM*MAX_DIM];
    cell_t c;
    int    n, m, pick;
    int    ra, ca, cb;
    ra = usable_dim(cfg_dims.ra);
    ca = usable_dim(cfg_dims.ca);
    cb = usable_dim(cfg_dims.cb);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) offer(cell_t'(CELL_W'($urandom)), 1'b0);
    if (ca != usable_dim(cfg_dims.rb)) begin
      n = $urandom_range(1, 3);
      for (m = 0; m < n; m++) offer(cell_t'(CELL_W'($urandom)), m == n - 1);
    end else if (operands_loaded() && $urandom_range(0, 3) == 0) begin
      // touch up a few elements and run again
      n = $urandom_range(1, 4);
      for (m = 0; m < n; m++) begin
        if ($urandom_range(0, 1) == 0) begin
          c.target = 1'b0;
          c.row = IDX_W'($urandom_range(0, ra - 1));
          c.col = IDX_W'($urandom_range(0, ca - 1));
        end else begin
          c.target = 1'b1;
          c.row = IDX_W'($urandom_range(0, ca - 1));
          c.col = IDX_W'($urandom_range(0, cb - 1));
        end
        offer(c, m == n - 1);
      end
    end else begin
      n = 0;
      for (int i = 0; i < ra; i++)
        for (int k = 0; k < ca; k++) begin
          cells[n] = '{1'b0, i[IDX_W-1:0], k[IDX_W-1:0]};
          n++;
        end
      for (int k = 0; k < ca; k++)
        for (int j = 0; j < cb; j++) begin
          cells[n] = '{1'b1, k[IDX_W-1:0], j[IDX_W-1:0]};
          n++;
        end
      for (m = n - 1; m > 0; m--) begin
        pick = $urandom_range(0, m);
        c = cells[m];
        cells[m] = cells[pick];
        cells[pick] = c;
      end
      for (m = 0; m < n; m++) offer(cells[m], m == n - 1);
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].reconfig) set_dims(DIRECTED[r].dims);
      mark_loaded(DIRECTED[r].ld);
      drive_load(DIRECTED[r].ld, DIRECTED[r].typed, DIRECTED[r].want);
    end
    while (n_random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) random_dims();
      random_sequence();
    end
    wait_idle();
    $display("matrix_multiply: %0d loads taken over %0d dimension settings",
             n_loaded, n_configs);
    $display("  %0d product elements (%0d clipped) and %0d mismatch flags checked",
             n_products, n_saturated, n_dim_errors);
    if (n_fail == 0 && pending_products.size() == 0) begin
      $display("** matrix_multiply: PASSED **");
    end else begin
      $display("%0d failures", n_fail);
      $display("** matrix_multiply: FAILED **");
    end
    $finish;
  end

endmodule

@@ matrix_multiply.f @@
design/mm_pkg.sv
design/mm_ram.sv
design/mm_mac.sv
design/matrix_multiply.sv
tb/sv/tb.sv
